// ----- rtl/sfe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfe_pkg
// Shared types, command codes, register indexes and fixed-point constants of
// the smoothstep fade envelope.
// ----------------------------------------------------------------------------
package sfe_pkg;

  // item commands
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_INTENSITY      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIFE_TIME      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_OPACITY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_OPACITY    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_EMISSIVE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_EMISSIVE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FLICKER_ENABLE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FLICKER_SPEED  = 3'd7;

  // fixed-point constants
  localparam int          T_FRAC_BITS = 16;             // phase quotient bits
  localparam logic [16:0] ONE_Q16     = 17'd65536;
  localparam logic [16:0] EDGE_IN     = 17'd9830;       // 0.15
  localparam logic [16:0] EDGE_OUT    = 17'd42598;      // 0.65
  localparam logic [14:0] SPAN_OUT    = 15'd22938;      // 1 - 0.65
  localparam logic [18:0] RECIP_IN    = 19'd436924;     // floor(2^32 / 9830)
  localparam logic [18:0] RECIP_OUT   = 19'd187242;     // floor(2^32 / 22938)
  localparam logic [29:0] INV_TWO_PI  = 30'd683565276;  // 1/(2pi), Q0.32
  localparam logic [16:0] FACTOR_MID  = 17'd49152;      // 0.75
  localparam logic [17:0] SMOOTH_3    = 18'd196608;     // 3.0
  localparam logic [23:0] LIFE_MIN    = 24'd655;        // 0.01 s

  typedef struct packed {
    logic [1:0]  command;
    logic [23:0] delta_time;
  } in_item_t;

  typedef struct packed {
    logic [15:0] opacity;
    logic [15:0] emissive;
    logic        active;
    logic        finished;
  } out_item_t;

  // datapath arithmetic steps
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LVL_A,     // prod = min * (1 - intensity)
    OP_LVL_B,     // acc = prod, prod = max * intensity
    OP_LVL_C,     // level = (acc + prod) >> 16
    OP_ANG,       // prod = elapsed * speed
    OP_TURN_LO,   // prod = angle[23:0] * K
    OP_TURN_HI,   // prod = angle[47:24] * K
    OP_IDX,       // sine table index
    OP_FACT,      // flicker factor
    OP_Q_R,       // quotient estimate by reciprocal
    OP_Q_D,       // back-multiply by divisor
    OP_Q_C,       // quotient correction
    OP_SQ_U,
    OP_SM_U,
    OP_SQ_V,
    OP_SM_V,
    OP_ALPHA,
    OP_ALPHA_ST,
    OP_FLICK,
    OP_FLICK_ST,
    OP_OUT_A,
    OP_OUT_B
  } sfe_op_t;

  typedef struct packed {
    sfe_op_t op;
    logic    sel;            // 0: fade in / opacity, 1: fade out / emissive
    logic    accum;          // add delta_time to elapsed time
    logic    clear_elapsed;
    logic    div_init;
    logic    div_step;
    logic    t_store;
    logic    load_out;
    logic    zero_out;
    logic    active;
    logic    finished;
  } sfe_ctrl_t;

  typedef struct packed {
    logic t_done;
    logic flicker_en;
  } sfe_stat_t;

endpackage

// ----- rtl/sfe_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfe_datapath
// Configuration registers, elapsed time, bit-serial phase divider, shared
// multiplier with its operand selection, sine table and result register.
// ----------------------------------------------------------------------------
module sfe_datapath #(
  parameter int SINE_TABLE_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sfe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sfe_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [23:0]                         delta_time,
  input  sfe_pkg::sfe_ctrl_t                  ctrl,
  output sfe_pkg::sfe_stat_t                  stat,
  output sfe_pkg::out_item_t                  out_data
);

  localparam int TableDepth  = 1 << SINE_TABLE_BITS;
  localparam int QuarterBits = SINE_TABLE_BITS - 2;

  // quarter-wave polynomial, evaluated at elaboration only
  function automatic logic [16:0] sine_mag(input int unsigned i);
    int unsigned     q;
    int unsigned     r;
    longint unsigned z;
    longint unsigned z2;
    longint unsigned p;
    q = i >> QuarterBits;
    r = i & ((1 << QuarterBits) - 1);
    z = longint'(r) << (16 - QuarterBits);
    if ((q & 1) != 0) z = 65536 - z;
    z2 = (z * z) >> 16;
    p = 307;
    p = 5223 - ((z2 * p) >> 16);
    p = 42334 - ((z2 * p) >> 16);
    p = 102944 - ((z2 * p) >> 16);
    p = (z * p) >> 16;
    if (p > 65536) p = 65536;
    return 17'(p);
  endfunction

  logic [16:0] sine_rom [TableDepth];
  for (genvar g = 0; g < TableDepth; g++) begin : g_rom
    assign sine_rom[g] = sine_mag(g);
  end

  // configuration
  logic [16:0] intensity_r;
  logic [23:0] life_time_r;
  logic [15:0] min_opacity_r, max_opacity_r, min_emissive_r, max_emissive_r;
  logic        flicker_enable_r;
  logic [15:0] flicker_speed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      intensity_r      <= '0;
      life_time_r      <= sfe_pkg::LIFE_MIN;
      min_opacity_r    <= '0;
      max_opacity_r    <= 16'hFFFF;
      min_emissive_r   <= '0;
      max_emissive_r   <= 16'd256;
      flicker_enable_r <= 1'b0;
      flicker_speed_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sfe_pkg::REG_INTENSITY:
          intensity_r <= (cfg_data[16:0] > sfe_pkg::ONE_Q16) ? sfe_pkg::ONE_Q16
                                                             : cfg_data[16:0];
        sfe_pkg::REG_LIFE_TIME:
          life_time_r <= (cfg_data < sfe_pkg::LIFE_MIN) ? sfe_pkg::LIFE_MIN : cfg_data;
        sfe_pkg::REG_MIN_OPACITY:    min_opacity_r    <= cfg_data[15:0];
        sfe_pkg::REG_MAX_OPACITY:    max_opacity_r    <= cfg_data[15:0];
        sfe_pkg::REG_MIN_EMISSIVE:   min_emissive_r   <= cfg_data[15:0];
        sfe_pkg::REG_MAX_EMISSIVE:   max_emissive_r   <= cfg_data[15:0];
        sfe_pkg::REG_FLICKER_ENABLE: flicker_enable_r <= cfg_data[0];
        sfe_pkg::REG_FLICKER_SPEED:  flicker_speed_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // elapsed time, saturating
  logic [31:0] elapsed_r, elapsed_nxt;
  logic [32:0] elapsed_sum;

  assign elapsed_sum = {1'b0, elapsed_r} + 33'(delta_time);

  always_comb begin
    elapsed_nxt = elapsed_r;
    if (ctrl.clear_elapsed)  elapsed_nxt = '0;
    else if (ctrl.accum)     elapsed_nxt = elapsed_sum[32] ? 32'hFFFF_FFFF : elapsed_sum[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) elapsed_r <= '0;
    else        elapsed_r <= elapsed_nxt;
  end

  // phase divider: (elapsed << 16) / life_time, one quotient bit per cycle
  logic [23:0] rem_r;
  logic [15:0] quo_r;
  logic        full_r;
  logic [24:0] rem_dbl;
  logic        rem_ge;
  logic [16:0] t_r;

  assign rem_dbl = {rem_r, 1'b0};
  assign rem_ge  = rem_dbl >= {1'b0, life_time_r};

  always_ff @(posedge clk) begin
    if (ctrl.div_init) begin
      rem_r  <= elapsed_r[23:0];
      quo_r  <= '0;
      full_r <= elapsed_r >= {8'h00, life_time_r};
    end else if (ctrl.div_step) begin
      rem_r <= rem_ge ? 24'(rem_dbl - {1'b0, life_time_r}) : rem_dbl[23:0];
      quo_r <= {quo_r[14:0], rem_ge};
    end
    if (ctrl.t_store) t_r <= full_r ? sfe_pkg::ONE_Q16 : {1'b0, quo_r};
  end

  // fade in / fade out numerators
  logic [14:0] x_in, x_out, x_q;
  logic [31:0] q_diff;
  logic        q_corr;

  assign x_in  = (t_r >= sfe_pkg::EDGE_IN) ? sfe_pkg::EDGE_IN[14:0] : t_r[14:0];
  assign x_out = (t_r > sfe_pkg::EDGE_OUT) ? 15'(t_r - sfe_pkg::EDGE_OUT) : '0;
  assign x_q   = ctrl.sel ? x_out : x_in;

  // working registers
  logic [63:0] prod_r;
  logic [31:0] acc_r;
  logic [15:0] lvl_o_r, lvl_e_r;
  logic [23:0] hi_r;
  logic [29:0] tlo_r;
  logic [SINE_TABLE_BITS-1:0] idx_r;
  logic [16:0] fact_r, q_r, u_r, v_r, su_r, alpha_r;
  logic [15:0] res_o_r, res_e_r;
  sfe_pkg::out_item_t out_r;

  assign q_diff = 32'({x_q, 16'h0000}) - prod_r[31:0];
  assign q_corr = q_diff >= (ctrl.sel ? 32'(sfe_pkg::SPAN_OUT) : 32'(sfe_pkg::EDGE_IN));

  logic [32:0] lvl_sum;
  logic [31:0] turn_sum;
  logic [16:0] mag;

  assign lvl_sum  = {1'b0, acc_r} + {1'b0, prod_r[31:0]};
  assign turn_sum = prod_r[31:0] + {2'b00, tlo_r};
  assign mag      = sine_rom[idx_r];

  // shared multiplier operands
  logic [33:0] mul_a;
  logic [29:0] mul_b;
  logic        mul_en;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (ctrl.op)
      sfe_pkg::OP_LVL_A: begin
        mul_a = 34'(ctrl.sel ? min_emissive_r : min_opacity_r);
        mul_b = 30'(sfe_pkg::ONE_Q16 - intensity_r);
      end
      sfe_pkg::OP_LVL_B: begin
        mul_a = 34'(ctrl.sel ? max_emissive_r : max_opacity_r);
        mul_b = 30'(intensity_r);
      end
      sfe_pkg::OP_ANG: begin
        mul_a = 34'(elapsed_r);
        mul_b = 30'(flicker_speed_r);
      end
      sfe_pkg::OP_TURN_LO: begin
        mul_a = 34'(prod_r[23:0]);
        mul_b = sfe_pkg::INV_TWO_PI;
      end
      sfe_pkg::OP_TURN_HI: begin
        mul_a = 34'(hi_r);
        mul_b = sfe_pkg::INV_TWO_PI;
      end
      sfe_pkg::OP_Q_R: begin
        mul_a = 34'(x_q);
        mul_b = 30'(ctrl.sel ? sfe_pkg::RECIP_OUT : sfe_pkg::RECIP_IN);
      end
      sfe_pkg::OP_Q_D: begin
        mul_a = 34'(prod_r[32:16]);
        mul_b = ctrl.sel ? 30'(sfe_pkg::SPAN_OUT) : 30'(sfe_pkg::EDGE_IN);
      end
      sfe_pkg::OP_SQ_U: begin
        mul_a = 34'(u_r);
        mul_b = 30'(u_r);
      end
      sfe_pkg::OP_SM_U: begin
        mul_a = prod_r[33:0];
        mul_b = 30'(sfe_pkg::SMOOTH_3 - {u_r, 1'b0});
      end
      sfe_pkg::OP_SQ_V: begin
        mul_a = 34'(v_r);
        mul_b = 30'(v_r);
      end
      sfe_pkg::OP_SM_V: begin
        mul_a = prod_r[33:0];
        mul_b = 30'(sfe_pkg::SMOOTH_3 - {v_r, 1'b0});
      end
      sfe_pkg::OP_ALPHA: begin
        mul_a = 34'(su_r);
        mul_b = 30'(sfe_pkg::ONE_Q16 - prod_r[48:32]);
      end
      sfe_pkg::OP_FLICK: begin
        mul_a = 34'(alpha_r);
        mul_b = 30'(fact_r);
      end
      sfe_pkg::OP_OUT_A: begin
        mul_a = 34'(ctrl.sel ? lvl_e_r : lvl_o_r);
        mul_b = 30'(alpha_r);
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) prod_r <= {30'b0, mul_a} * {34'b0, mul_b};
    case (ctrl.op)
      sfe_pkg::OP_LVL_B:    acc_r <= prod_r[31:0];
      sfe_pkg::OP_LVL_C: begin
        if (ctrl.sel) lvl_e_r <= lvl_sum[31:16];
        else          lvl_o_r <= lvl_sum[31:16];
      end
      sfe_pkg::OP_TURN_LO:  hi_r  <= prod_r[47:24];
      sfe_pkg::OP_TURN_HI:  tlo_r <= prod_r[53:24];
      sfe_pkg::OP_IDX:      idx_r <= turn_sum[31 -: SINE_TABLE_BITS];
      // lower half wave subtracts
      sfe_pkg::OP_FACT:
        fact_r <= idx_r[SINE_TABLE_BITS-1] ? sfe_pkg::FACTOR_MID - (mag >> 2)
                                           : sfe_pkg::FACTOR_MID + (mag >> 2);
      sfe_pkg::OP_Q_D:      q_r <= prod_r[32:16];
      sfe_pkg::OP_Q_C: begin
        if (ctrl.sel) v_r <= q_r + 17'(q_corr);
        else          u_r <= q_r + 17'(q_corr);
      end
      sfe_pkg::OP_SQ_V:     su_r    <= prod_r[48:32];
      sfe_pkg::OP_ALPHA_ST: alpha_r <= prod_r[32:16];
      sfe_pkg::OP_FLICK_ST: alpha_r <= prod_r[32:16];
      sfe_pkg::OP_OUT_B: begin
        if (ctrl.sel) res_e_r <= prod_r[31:16];
        else          res_o_r <= prod_r[31:16];
      end
      default: ;
    endcase
    if (ctrl.load_out) begin
      out_r.opacity  <= ctrl.zero_out ? 16'h0000 : res_o_r;
      out_r.emissive <= ctrl.zero_out ? 16'h0000 : res_e_r;
      out_r.active   <= ctrl.active;
      out_r.finished <= ctrl.finished;
    end
  end

  assign stat.t_done     = t_r[16];
  assign stat.flicker_en = flicker_enable_r;
  assign out_data        = out_r;

endmodule

// ----- rtl/sfe_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfe_ctrl
// Sequencer of the fade envelope: item handshake, running flag, divider
// stepping and the ordered list of multiplier steps.
// ----------------------------------------------------------------------------
module sfe_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_cmd,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  sfe_pkg::sfe_stat_t stat,
  output sfe_pkg::sfe_ctrl_t ctrl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_INIT,
    S_DIV,
    S_T_ST,
    S_SEQ,
    S_LOAD
  } state_t;

  localparam logic [4:0] DivLast = 5'(sfe_pkg::T_FRAC_BITS - 1);
  localparam logic [4:0] SeqLast = 5'd17;

  state_t     state_r;
  logic [4:0] cnt_r;
  logic       running_r;
  logic       out_valid_r;
  logic       compute_r;
  logic       act_r;
  logic       slot_free;
  logic       run_tick;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;
  // only a tick while running goes through the datapath
  assign run_tick  = (in_cmd == sfe_pkg::CMD_TICK) && running_r;

  // level and flicker angle work runs on the multiplier during the division
  sfe_pkg::sfe_op_t div_op;
  logic             div_sel;

  always_comb begin
    div_op  = sfe_pkg::OP_NONE;
    div_sel = 1'b0;
    case (cnt_r)
      5'd0:  div_op = sfe_pkg::OP_LVL_A;
      5'd1:  div_op = sfe_pkg::OP_LVL_B;
      5'd2:  div_op = sfe_pkg::OP_LVL_C;
      5'd3:  begin div_op = sfe_pkg::OP_LVL_A; div_sel = 1'b1; end
      5'd4:  begin div_op = sfe_pkg::OP_LVL_B; div_sel = 1'b1; end
      5'd5:  begin div_op = sfe_pkg::OP_LVL_C; div_sel = 1'b1; end
      5'd6:  div_op = sfe_pkg::OP_ANG;
      5'd7:  div_op = sfe_pkg::OP_TURN_LO;
      5'd8:  div_op = sfe_pkg::OP_TURN_HI;
      5'd9:  div_op = sfe_pkg::OP_IDX;
      5'd10: div_op = sfe_pkg::OP_FACT;
      default: ;
    endcase
  end

  sfe_pkg::sfe_op_t seq_op;
  logic             seq_sel;

  always_comb begin
    seq_op  = sfe_pkg::OP_NONE;
    seq_sel = 1'b0;
    case (cnt_r)
      5'd0:  seq_op = sfe_pkg::OP_Q_R;
      5'd1:  seq_op = sfe_pkg::OP_Q_D;
      5'd2:  seq_op = sfe_pkg::OP_Q_C;
      5'd3:  begin seq_op = sfe_pkg::OP_Q_R; seq_sel = 1'b1; end
      5'd4:  begin seq_op = sfe_pkg::OP_Q_D; seq_sel = 1'b1; end
      5'd5:  begin seq_op = sfe_pkg::OP_Q_C; seq_sel = 1'b1; end
      5'd6:  seq_op = sfe_pkg::OP_SQ_U;
      5'd7:  seq_op = sfe_pkg::OP_SM_U;
      5'd8:  seq_op = sfe_pkg::OP_SQ_V;
      5'd9:  seq_op = sfe_pkg::OP_SM_V;
      5'd10: seq_op = sfe_pkg::OP_ALPHA;
      5'd11: seq_op = sfe_pkg::OP_ALPHA_ST;
      5'd12: if (stat.flicker_en) seq_op = sfe_pkg::OP_FLICK;
      5'd13: if (stat.flicker_en) seq_op = sfe_pkg::OP_FLICK_ST;
      5'd14: seq_op = sfe_pkg::OP_OUT_A;
      5'd15: seq_op = sfe_pkg::OP_OUT_B;
      5'd16: begin seq_op = sfe_pkg::OP_OUT_A; seq_sel = 1'b1; end
      5'd17: begin seq_op = sfe_pkg::OP_OUT_B; seq_sel = 1'b1; end
      default: ;
    endcase
  end

  always_comb begin
    ctrl    = '0;
    ctrl.op = sfe_pkg::OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.accum         = (in_cmd == sfe_pkg::CMD_TICK) && running_r;
          ctrl.clear_elapsed = (in_cmd == sfe_pkg::CMD_START) || (in_cmd == sfe_pkg::CMD_STOP);
        end
      end
      S_DIV_INIT: ctrl.div_init = 1'b1;
      S_DIV: begin
        ctrl.div_step = 1'b1;
        ctrl.op       = div_op;
        ctrl.sel      = div_sel;
      end
      S_T_ST: ctrl.t_store = 1'b1;
      S_SEQ: begin
        ctrl.op  = seq_op;
        ctrl.sel = seq_sel;
      end
      S_LOAD: begin
        ctrl.load_out      = slot_free;
        ctrl.zero_out      = !compute_r;
        ctrl.active        = compute_r ? !stat.t_done : act_r;
        ctrl.finished      = compute_r && stat.t_done;
        ctrl.clear_elapsed = slot_free && compute_r && stat.t_done;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      running_r   <= 1'b0;
      out_valid_r <= 1'b0;
      compute_r   <= 1'b0;
      act_r       <= 1'b0;
    end else begin
      // in the load step a taken result is replaced by the next one
      if (out_valid_r && out_ready && state_r != S_LOAD) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            compute_r <= run_tick;
            state_r   <= run_tick ? S_DIV_INIT : S_LOAD;
            case (in_cmd)
              sfe_pkg::CMD_START: begin
                running_r <= 1'b1;
                act_r     <= 1'b1;
              end
              sfe_pkg::CMD_STOP: begin
                running_r <= 1'b0;
                act_r     <= 1'b0;
              end
              sfe_pkg::CMD_TICK: act_r <= 1'b0;
              default: act_r <= running_r;
            endcase
          end
        end
        S_DIV_INIT: begin
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == DivLast) state_r <= S_T_ST;
        end
        S_T_ST: begin
          cnt_r   <= '0;
          state_r <= S_SEQ;
        end
        S_SEQ: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == SeqLast) state_r <= S_LOAD;
        end
        S_LOAD: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            if (compute_r && stat.t_done) running_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_LOAD))
    else $error("result raised outside load state");

  a_finish_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.load_out && ctrl.finished) |=> !running_r)
    else $error("envelope still running after finished item");

  a_run_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(running_r) |-> $past(in_valid && in_ready && in_cmd == sfe_pkg::CMD_START))
    else $error("running set without start item");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r <= DivLast))
    else $error("divider step count overrun");
`endif

endmodule

// ----- rtl/smoothstep_fade_envelope.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smoothstep_fade_envelope
// One-shot smoothstep fade envelope with optional sine flicker, in fixed point.
// ----------------------------------------------------------------------------
// Usage:
//  in_valid/in_ready carry one item: a command (tick, start, stop) and a tick
//  delta_time. Every item gives exactly one result on out_valid/out_ready:
//  opacity, emissive, active and finished.
//  Start, stop, unused commands and ticks while stopped go from the accept
//  straight to the result load; the next item is taken after the result load.
//  Running tick: divider load, the 16-step phase divider, phase store, the 18
//  steps of the single shared 34x30 multiplier that follow it and the result
//  load run in that order; no new item is taken before the result load is done.
//  in_ready is high whenever the sequencer is idle, also while a result still
//  waits in the output register; a stalled receiver holds the next result in
//  the load step until the register empties.
//  cfg_we writes register cfg_index with cfg_data at once; write only while
//  no item is in flight.
//  Reset (rst_n low, synchronous) restores the configuration registers, clears
//  the elapsed time and leaves the envelope stopped; no clearing pass is needed.
// ----------------------------------------------------------------------------
module smoothstep_fade_envelope #(
  parameter int SINE_TABLE_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  sfe_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output sfe_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [sfe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfe_pkg::CFG_DATA_W-1:0] cfg_data
);

  sfe_pkg::sfe_ctrl_t ctrl;
  sfe_pkg::sfe_stat_t stat;

  sfe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_data.command),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  sfe_datapath #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .delta_time (in_data.delta_time),
    .ctrl       (ctrl),
    .stat       (stat),
    .out_data   (out_data)
  );

endmodule

// ----- verif/tb_smoothstep_fade_envelope.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_smoothstep_fade_envelope
// Self-checking bench for the fade envelope. Items go in and results come out
// over valid/ready with random gaps and stalls on both sides. A bit-exact
// envelope predictor keeps its own copy of the registers, elapsed time and
// run state, and a scoreboard checks every result field against it. A
// directed set of start/stop/tick items runs first. Random phases follow,
// each with fresh register settings and mostly complete start-to-finish
// envelopes.
// ----------------------------------------------------------------------------
module tb_smoothstep_fade_envelope;

  localparam int          SINE_BITS      = 8;
  localparam int          IDX_W          = sfe_pkg::CFG_IDX_W;
  localparam logic [1:0]  CMD_NOP        = 2'd3;          // unused command code
  localparam logic [63:0] PHASE_ONE      = 64'd65536;     // 1.0 in Q0.16
  localparam logic [63:0] FADE_IN_END    = 64'd9830;      // 0.15
  localparam logic [63:0] FADE_OUT_START = 64'd42598;     // 0.65
  localparam logic [63:0] FADE_OUT_SPAN  = 64'd22938;
  localparam logic [63:0] TURN_SCALE     = 64'd683565276; // 1/(2pi) in Q0.32
  localparam logic [63:0] FLICKER_BASE   = 64'd49152;     // 0.75
  localparam logic [23:0] LIFE_FLOOR     = 24'd655;
  localparam int          ITEM_TARGET    = 650;
  localparam int          PHASE_ITEMS    = 70;
  localparam int          TAIL_CYCLES    = 48;
  localparam int          TIMEOUT_NS     = 5_000_000;

  class envelope_scoreboard;
    logic [16:0] intensity;
    logic [23:0] life;
    logic [15:0] op_lo, op_hi, em_lo, em_hi, flick_speed;
    logic        flick_en;
    logic [31:0] elapsed;
    logic        running;
    sfe_pkg::out_item_t expected_q[$];
    int unsigned errors, items, results, finishes, flicker_ticks;

    function new();
      intensity   = '0;
      life        = LIFE_FLOOR;
      op_lo       = '0;
      op_hi       = 16'hFFFF;
      em_lo       = '0;
      em_hi       = 16'd256;
      flick_en    = 1'b0;
      flick_speed = '0;
      elapsed     = '0;
      running     = 1'b0;
    endfunction

    function void write_reg(logic [sfe_pkg::CFG_IDX_W-1:0] idx,
                            logic [sfe_pkg::CFG_DATA_W-1:0] d);
      case (idx)
        sfe_pkg::REG_INTENSITY:
          intensity = (d[16:0] > PHASE_ONE[16:0]) ? PHASE_ONE[16:0] : d[16:0];
        sfe_pkg::REG_LIFE_TIME:      life        = (d < LIFE_FLOOR) ? LIFE_FLOOR : d;
        sfe_pkg::REG_MIN_OPACITY:    op_lo       = d[15:0];
        sfe_pkg::REG_MAX_OPACITY:    op_hi       = d[15:0];
        sfe_pkg::REG_MIN_EMISSIVE:   em_lo       = d[15:0];
        sfe_pkg::REG_MAX_EMISSIVE:   em_hi       = d[15:0];
        sfe_pkg::REG_FLICKER_ENABLE: flick_en    = d[0];
        sfe_pkg::REG_FLICKER_SPEED:  flick_speed = d[15:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] smooth(logic [63:0] x);
      return (x * x * (3 * PHASE_ONE - 2 * x)) >> 32;
    endfunction

    function logic [15:0] blend(logic [15:0] lo, logic [15:0] hi, logic [63:0] alpha);
      logic [63:0] level;
      level = (64'(lo) * (PHASE_ONE - 64'(intensity)) + 64'(hi) * 64'(intensity)) >> 16;
      return 16'((level * alpha) >> 16);
    endfunction

    // advances the envelope state by one item and returns its result
    function sfe_pkg::out_item_t envelope_step(sfe_pkg::in_item_t it);
      sfe_pkg::out_item_t     r;
      logic [63:0]            sum, t, u, v, alpha, angle, turns, z, z2, p, factor;
      logic [SINE_BITS-1:0]   sidx;
      logic [1:0]             quad;
      r = '0;
      case (it.command)
        sfe_pkg::CMD_START: begin
          elapsed = '0;
          running = 1'b1;
        end
        sfe_pkg::CMD_STOP: begin
          elapsed = '0;
          running = 1'b0;
        end
        sfe_pkg::CMD_TICK: if (running) begin
          sum = 64'(elapsed) + 64'(it.delta_time);
          elapsed = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
          if (elapsed >= 32'(life))
            t = PHASE_ONE;
          else
            t = (64'(elapsed) << 16) / 64'(life);
          u = ((t < FADE_IN_END ? t : FADE_IN_END) * PHASE_ONE) / FADE_IN_END;
          v = (t > FADE_OUT_START) ? ((t - FADE_OUT_START) * PHASE_ONE) / FADE_OUT_SPAN : '0;
          if (v > PHASE_ONE) v = PHASE_ONE;
          alpha = (smooth(u) * (PHASE_ONE - smooth(v))) >> 16;
          if (flick_en) begin
            flicker_ticks++;
            angle = 64'(elapsed) * 64'(flick_speed);
            turns = 64'(angle[63:24]) * TURN_SCALE + ((64'(angle[23:0]) * TURN_SCALE) >> 24);
            sidx = turns[31 -: SINE_BITS];
            quad = sidx[SINE_BITS-1 -: 2];
            z = 64'(sidx[SINE_BITS-3:0]) << (16 - (SINE_BITS - 2));
            if (quad[0]) z = PHASE_ONE - z;
            // quarter-wave polynomial, Horner form in Q0.16
            z2 = (z * z) >> 16;
            p = 64'd307;
            p = 64'd5223 - ((z2 * p) >> 16);
            p = 64'd42334 - ((z2 * p) >> 16);
            p = 64'd102944 - ((z2 * p) >> 16);
            p = (z * p) >> 16;
            if (p > PHASE_ONE) p = PHASE_ONE;
            factor = quad[1] ? FLICKER_BASE - (p >> 2) : FLICKER_BASE + (p >> 2);
            alpha = (alpha * factor) >> 16;
          end
          r.opacity  = blend(op_lo, op_hi, alpha);
          r.emissive = blend(em_lo, em_hi, alpha);
          if (t >= PHASE_ONE) begin
            running    = 1'b0;
            elapsed    = '0;
            r.finished = 1'b1;
            finishes++;
          end
        end
        default: ;
      endcase
      r.active = running;
      return r;
    endfunction

    function void note_input(sfe_pkg::in_item_t it);
      items++;
      expected_q.push_back(envelope_step(it));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      errors++;
      $display("%0t ns  result %0d: %s", $time, results, msg);
    endtask

    task check_result(sfe_pkg::out_item_t got);
      sfe_pkg::out_item_t want;
      results++;
      if (expected_q.size() == 0) begin
        report("result with no item outstanding");
        return;
      end
      want = expected_q.pop_front();
      if (got.opacity !== want.opacity)
        report($sformatf("opacity %0d, expected %0d", got.opacity, want.opacity));
      if (got.emissive !== want.emissive)
        report($sformatf("emissive %0d, expected %0d", got.emissive, want.emissive));
      if (got.active !== want.active)
        report($sformatf("active %b, expected %b", got.active, want.active));
      if (got.finished !== want.finished)
        report($sformatf("finished %b, expected %b", got.finished, want.finished));
    endtask
  endclass

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  sfe_pkg::in_item_t              in_data   = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  sfe_pkg::out_item_t             out_data;
  logic                           cfg_we    = 1'b0;
  logic [sfe_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [sfe_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  logic [sfe_pkg::CFG_DATA_W-1:0] cfg_plan [8];
  bit                    src_quiet  = 1'b0;
  bit                    sink_quiet = 1'b0;
  int unsigned           settings   = 1;

  envelope_scoreboard sb = new();

  always #4 clk = ~clk;

  smoothstep_fade_envelope #(.SINE_TABLE_BITS(SINE_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_data);
  end

  // result side: random stall after each accepted result, none in quiet phases
  initial begin : result_sink
    int unsigned stall;
    @(posedge clk iff rst_n);
    out_ready <= 1'b1;
    forever begin
      do @(posedge clk); while (!(out_valid && out_ready));
      stall = sink_quiet ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // valid stays up across back-to-back items; it drops only for a gap
  task automatic send_item(input logic [1:0] cmd, input logic [23:0] dt);
    sfe_pkg::in_item_t it;
    int unsigned       gap;
    it.command    = cmd;
    it.delta_time = dt;
    gap = src_quiet ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
  endtask

  // hold off until every result is back, then let the sequencer go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs();
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= IDX_W'(i);
      cfg_data  <= cfg_plan[i];
      @(posedge clk);
      sb.write_reg(IDX_W'(i), cfg_plan[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [23:0] pick(logic [23:0] top);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return top;
      2:       return 24'($urandom());
      default: return 24'($urandom_range(0, top));
    endcase
  endfunction

  // mostly whole envelopes paced to the lifetime, the rest raw noise
  task automatic random_traffic(input int unsigned count);
    int unsigned target, n, step;
    target = sb.items + count;
    while (sb.items < target) begin
      if ($urandom_range(0, 4) != 0) begin
        n    = $urandom_range(2, 24);
        step = sb.life / n;
        send_item(sfe_pkg::CMD_START, 24'($urandom()));
        for (int k = 0; k < n; k++) begin
          case ($urandom_range(0, 39))
            0:       send_item(CMD_NOP, 24'($urandom()));
            1:       send_item(sfe_pkg::CMD_STOP, 24'($urandom()));
            default: ;
          endcase
          send_item(sfe_pkg::CMD_TICK, 24'(step + $urandom_range(0, step)));
        end
      end else begin
        send_item(2'($urandom()), 24'($urandom()));
      end
    end
  endtask

  initial begin : stimulus
    int unsigned phase, waited;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: lifetime 655, plain fade
    send_item(sfe_pkg::CMD_TICK, 24'd0);          // tick while stopped
    send_item(CMD_NOP, 24'hFFFFFF);               // unused command while stopped
    send_item(sfe_pkg::CMD_STOP, 24'd0);
    send_item(sfe_pkg::CMD_START, 24'hFFFFFF);
    send_item(CMD_NOP, 24'd0);                    // unused command while running
    send_item(sfe_pkg::CMD_TICK, 24'd0);
    send_item(sfe_pkg::CMD_TICK, 24'd1);
    send_item(sfe_pkg::CMD_TICK, 24'd97);         // fade in
    send_item(sfe_pkg::CMD_TICK, 24'd300);        // plateau
    send_item(sfe_pkg::CMD_TICK, 24'd70);         // fade out
    send_item(sfe_pkg::CMD_TICK, 24'd80);
    send_item(sfe_pkg::CMD_TICK, 24'hFFFFFF);     // overshoot, finishes
    send_item(sfe_pkg::CMD_TICK, 24'd10);         // after finish
    send_item(sfe_pkg::CMD_START, 24'd0);
    send_item(sfe_pkg::CMD_TICK, 24'hFFFFFF);     // finishes on the first tick
    send_item(sfe_pkg::CMD_START, 24'd0);
    send_item(sfe_pkg::CMD_TICK, 24'd200);
    send_item(sfe_pkg::CMD_STOP, 24'hFFFFFF);
    send_item(sfe_pkg::CMD_TICK, 24'd5);
    send_item(sfe_pkg::CMD_START, 24'd0);
    send_item(sfe_pkg::CMD_START, 24'd0);         // restart while running
    send_item(sfe_pkg::CMD_TICK, 24'd655);        // lands exactly on the lifetime

    phase = 0;
    while (sb.items < ITEM_TARGET) begin
      settle();
      case (phase)
        0: begin
          // clamps and inverted ranges, fastest flicker
          cfg_plan[sfe_pkg::REG_INTENSITY]      = 24'h01FFFF;
          cfg_plan[sfe_pkg::REG_LIFE_TIME]      = 24'd0;
          cfg_plan[sfe_pkg::REG_MIN_OPACITY]    = 24'h00FFFF;
          cfg_plan[sfe_pkg::REG_MAX_OPACITY]    = 24'd0;
          cfg_plan[sfe_pkg::REG_MIN_EMISSIVE]   = 24'h00FFFF;
          cfg_plan[sfe_pkg::REG_MAX_EMISSIVE]   = 24'h00FFFF;
          cfg_plan[sfe_pkg::REG_FLICKER_ENABLE] = 24'd1;
          cfg_plan[sfe_pkg::REG_FLICKER_SPEED]  = 24'h00FFFF;
        end
        1: begin
          cfg_plan[sfe_pkg::REG_INTENSITY]      = 24'(PHASE_ONE);
          cfg_plan[sfe_pkg::REG_LIFE_TIME]      = 24'hFFFFFF;
          cfg_plan[sfe_pkg::REG_MIN_OPACITY]    = 24'd0;
          cfg_plan[sfe_pkg::REG_MAX_OPACITY]    = 24'hFFFFFF;
          cfg_plan[sfe_pkg::REG_MIN_EMISSIVE]   = 24'd0;
          cfg_plan[sfe_pkg::REG_MAX_EMISSIVE]   = 24'h00FFFF;
          cfg_plan[sfe_pkg::REG_FLICKER_ENABLE] = 24'hFFFFFF;
          cfg_plan[sfe_pkg::REG_FLICKER_SPEED]  = 24'd0;
        end
        default: begin
          cfg_plan[sfe_pkg::REG_INTENSITY]      = pick(24'(PHASE_ONE));
          cfg_plan[sfe_pkg::REG_LIFE_TIME]      = ($urandom_range(0, 2) != 0) ?
                                                  24'($urandom_range(0, 20000)) :
                                                  pick(24'hFFFFFF);
          cfg_plan[sfe_pkg::REG_MIN_OPACITY]    = pick(24'h00FFFF);
          cfg_plan[sfe_pkg::REG_MAX_OPACITY]    = pick(24'h00FFFF);
          cfg_plan[sfe_pkg::REG_MIN_EMISSIVE]   = pick(24'h00FFFF);
          cfg_plan[sfe_pkg::REG_MAX_EMISSIVE]   = pick(24'h00FFFF);
          cfg_plan[sfe_pkg::REG_FLICKER_ENABLE] = 24'($urandom());
          cfg_plan[sfe_pkg::REG_FLICKER_SPEED]  = pick(24'h00FFFF);
        end
      endcase
      write_regs();
      settings++;
      src_quiet  = ($urandom_range(0, 3) == 0);
      sink_quiet = ($urandom_range(0, 3) == 0);
      random_traffic(PHASE_ITEMS);
      phase++;
    end

    in_valid <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));

    $display("covered %0d items under %0d register settings, %0d results checked",
             sb.items, settings, sb.results);
    $display("%0d envelopes ran to the end, %0d ticks went through the flicker path",
             sb.finishes, sb.flicker_ticks);
    if (sb.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("timeout: %0d items in, %0d results out", sb.items, sb.results);
    $display("== FAIL ==");
    $finish;
  end

endmodule
